/* rtl/mstt_pkg.sv */
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants of the second timer table
// Result codes, request codes and sequencer states.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int unsigned ENTRIES_DEF = 32;
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_TICK  = 2'd1,
        FN_DEL   = 2'd2,
        FN_QUERY = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        K_FIRED    = 3'd0,
        K_ADDED    = 3'd1,
        K_FULL     = 3'd2,
        K_QUERY    = 3'd3,
        K_DELETED  = 3'd4,
        K_TICKDONE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

endpackage

/* rtl/multi_slot_second_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// multi_slot_second_timer_table_unit: table of one-shot and periodic timers
// An add with zero total time answers in the cycle after acceptance; every
// other request scans the slots one per cycle through one shared update unit
// and, after the scan, registers its final result from the output state. A
// fire stalls the scan only while a held result waits on m_ready. No new
// request is taken until the block is idle and its output register is free.
// Reset clears all slot valid bits; per-slot stores hold no reset value.
// ----------------------------------------------------------------------------
module multi_slot_second_timer_table_unit #(
    parameter int unsigned ENTRIES = mstt_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_total_time,
    input  logic [31:0] s_interval,
    input  logic [15:0] s_tag,
    input  logic [31:0] s_user_param,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [4:0]  m_slot,
    output logic [15:0] m_fired_tag,
    output logic [31:0] m_fired_param,
    output logic [15:0] m_fire_count,
    output logic        m_found,
    output logic        m_last
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // per-slot state
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0] rnow_mem  [ENTRIES];
    logic [31:0] rtot_mem  [ENTRIES];
    logic [31:0] per_mem   [ENTRIES];
    logic        fev_mem   [ENTRIES];
    logic [15:0] tag_mem   [ENTRIES];
    logic [31:0] prm_mem   [ENTRIES];
    logic [15:0] fcnt_mem  [ENTRIES];

    mstt_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]  func_reg;
    logic [31:0] tot_reg, ivl_reg, prm_reg;
    logic [15:0] tag_reg;
    logic        hit_reg, hit_next;
    logic        free_ok_reg, free_ok_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    // output register
    logic        ov_reg, ov_next;
    logic [2:0]  ok_reg, ok_next;
    logic [4:0]  os_reg, os_next;
    logic [15:0] ot_reg, ot_next;
    logic [31:0] op_reg, op_next;
    logic [15:0] oc_reg, oc_next;
    logic        of_reg, of_next;
    logic        ol_reg, ol_next;

    logic last_idx, out_free, s_fire;
    logic        cur_v;
    logic [31:0] cur_now, cur_tot, cur_per;
    logic [15:0] cur_tag, cur_cnt, cnt_inc;
    logic        fire_now, tag_eq;

    assign last_idx = (idx_reg == IW'(ENTRIES - 1));
    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (state_reg == mstt_pkg::ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign cur_v    = valid_reg[idx_reg];
    assign cur_now  = rnow_mem[idx_reg];
    assign cur_tot  = rtot_mem[idx_reg];
    assign cur_per  = per_mem[idx_reg];
    assign cur_tag  = tag_mem[idx_reg];
    assign cur_cnt  = fcnt_mem[idx_reg];
    assign cnt_inc  = cur_cnt + 16'd1;
    assign fire_now = (cur_now <= 32'd1);
    assign tag_eq   = (cur_tag == tag_reg);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        ov_next = ov_reg && !m_ready;
        ok_next = ok_reg; os_next = os_reg; ot_next = ot_reg; op_next = op_reg;
        oc_next = oc_reg; of_next = of_reg; ol_next = ol_reg;
        case (state_reg)
            mstt_pkg::ST_IDLE: begin
                if (s_fire) begin
                    idx_next     = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    free_idx_next = '0;
                    if (mstt_pkg::func_t'(s_func) == mstt_pkg::FN_ADD
                            && s_total_time == 32'd0) begin
                        ov_next = 1'b1;
                        ok_next = mstt_pkg::K_FIRED;
                        os_next = '0;
                        ot_next = s_tag;
                        op_next = s_user_param;
                        oc_next = (s_interval != 32'd0) ? 16'd1 : 16'd0;
                        of_next = 1'b0;
                        ol_next = 1'b1;
                    end else begin
                        state_next = mstt_pkg::ST_SCAN;
                    end
                end
            end
            mstt_pkg::ST_SCAN: begin
                case (mstt_pkg::func_t'(func_reg))
                    mstt_pkg::FN_TICK: begin
                        // emit one fire per slot; wait while result is held
                        if (cur_v && fire_now) begin
                            if (out_free) begin
                                ov_next = 1'b1;
                                ok_next = mstt_pkg::K_FIRED;
                                os_next = 5'(idx_reg);
                                ot_next = cur_tag;
                                op_next = prm_mem[idx_reg];
                                oc_next = (cur_per != 32'd0) ? cnt_inc : 16'd0;
                                of_next = 1'b0;
                                ol_next = 1'b0;
                                if (last_idx) state_next = mstt_pkg::ST_OUT;
                                else idx_next = idx_reg + IW'(1);
                            end
                        end else if (last_idx) begin
                            state_next = mstt_pkg::ST_OUT;
                        end else begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                    mstt_pkg::FN_ADD: begin
                        if (!cur_v && !free_ok_reg) begin
                            free_ok_next  = 1'b1;
                            free_idx_next = idx_reg;
                        end
                        if (last_idx) state_next = mstt_pkg::ST_OUT;
                        else idx_next = idx_reg + IW'(1);
                    end
                    default: begin
                        if (cur_v && tag_eq) hit_next = 1'b1;
                        if (last_idx) state_next = mstt_pkg::ST_OUT;
                        else idx_next = idx_reg + IW'(1);
                    end
                endcase
            end
            mstt_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = mstt_pkg::ST_IDLE;
                    ov_next = 1'b1;
                    os_next = '0; ot_next = '0; op_next = '0; oc_next = '0;
                    of_next = 1'b0;
                    ol_next = 1'b1;
                    case (mstt_pkg::func_t'(func_reg))
                        mstt_pkg::FN_TICK: ok_next = mstt_pkg::K_TICKDONE;
                        mstt_pkg::FN_ADD: begin
                            if (free_ok_reg) begin
                                ok_next = mstt_pkg::K_ADDED;
                                os_next = 5'(free_idx_reg);
                            end else begin
                                ok_next = mstt_pkg::K_FULL;
                            end
                        end
                        mstt_pkg::FN_DEL: begin
                            ok_next = mstt_pkg::K_DELETED;
                            of_next = hit_reg;
                        end
                        default: begin
                            ok_next = mstt_pkg::K_QUERY;
                            of_next = hit_reg;
                        end
                    endcase
                end
            end
            default: state_next = mstt_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mstt_pkg::ST_IDLE;
            ov_reg      <= 1'b0;
            valid_reg   <= '0;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ov_reg      <= ov_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            free_ok_reg <= free_ok_next;
            if (state_reg == mstt_pkg::ST_SCAN && cur_v) begin
                if (mstt_pkg::func_t'(func_reg) == mstt_pkg::FN_DEL && tag_eq)
                    valid_reg[idx_reg] <= 1'b0;
                if (mstt_pkg::func_t'(func_reg) == mstt_pkg::FN_TICK && fire_now
                        && out_free
                        && (cur_per == 32'd0 || cur_tot == 32'd0))
                    valid_reg[idx_reg] <= 1'b0;
            end
            if (state_reg == mstt_pkg::ST_OUT && out_free
                    && mstt_pkg::func_t'(func_reg) == mstt_pkg::FN_ADD && free_ok_reg)
                valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // payload registers and slot stores
    always_ff @(posedge aclk) begin
        free_idx_reg <= free_idx_next;
        ok_reg <= ok_next; os_reg <= os_next; ot_reg <= ot_next; op_reg <= op_next;
        oc_reg <= oc_next; of_reg <= of_next; ol_reg <= ol_next;
        if (s_fire) begin
            func_reg <= s_func;
            tot_reg  <= s_total_time;
            ivl_reg  <= s_interval;
            tag_reg  <= s_tag;
            prm_reg  <= s_user_param;
        end
        // tick update of one slot
        if (state_reg == mstt_pkg::ST_SCAN && cur_v
                && mstt_pkg::func_t'(func_reg) == mstt_pkg::FN_TICK) begin
            if (!fire_now) begin
                rnow_mem[idx_reg] <= cur_now - 32'd1;
            end else if (out_free) begin
                fcnt_mem[idx_reg] <= cnt_inc;
                if (cur_per == 32'd0 || cur_tot == 32'd0) begin
                    rnow_mem[idx_reg] <= 32'd0;
                end else if (cur_tot < cur_per) begin
                    rnow_mem[idx_reg] <= cur_tot;
                    rtot_mem[idx_reg] <= 32'd0;
                end else begin
                    rnow_mem[idx_reg] <= cur_per;
                    if (!fev_mem[idx_reg]) rtot_mem[idx_reg] <= cur_tot - cur_per;
                end
            end
        end
        // add writes the whole slot
        if (state_reg == mstt_pkg::ST_OUT && out_free
                && mstt_pkg::func_t'(func_reg) == mstt_pkg::FN_ADD && free_ok_reg) begin
            per_mem[free_idx_reg]  <= ivl_reg;
            tag_mem[free_idx_reg]  <= tag_reg;
            prm_mem[free_idx_reg]  <= prm_reg;
            fcnt_mem[free_idx_reg] <= 16'd0;
            fev_mem[free_idx_reg]  <= (ivl_reg != 32'd0) && (tot_reg == mstt_pkg::ALL_ONES);
            if (ivl_reg != 32'd0) begin
                rnow_mem[free_idx_reg] <= ivl_reg;
                if (tot_reg == mstt_pkg::ALL_ONES) rtot_mem[free_idx_reg] <= mstt_pkg::ALL_ONES;
                else if (tot_reg < ivl_reg) rtot_mem[free_idx_reg] <= 32'd0;
                else rtot_mem[free_idx_reg] <= tot_reg - ivl_reg;
            end else begin
                rnow_mem[free_idx_reg] <= tot_reg;
                rtot_mem[free_idx_reg] <= 32'd0;
            end
        end
    end

    assign m_valid       = ov_reg;
    assign m_kind        = ok_reg;
    assign m_slot        = os_reg;
    assign m_fired_tag   = ot_reg;
    assign m_fired_param = op_reg;
    assign m_fire_count  = oc_reg;
    assign m_found       = of_reg;
    assign m_last        = ol_reg;

endmodule
